/* src/fdnrh_pkg.sv */
// shared constants for the feedback delay network reverb
package fdnrh_pkg;

    // parameter defaults
    localparam int LINES_DEF       = 4;
    localparam int MAX_DELAY_DEF   = 8192;
    localparam int SAMPLE_BITS_DEF = 24;

    // register file layout: gains first, then delay lengths
    localparam int NUM_LINE_REGS = 4;
    localparam int LINE_IDX_W    = 2;
    localparam int GAIN_W        = 16;
    localparam int LEN_W         = 14;
    localparam int REG_IDX_W     = 3;
    localparam int PADDR_W       = REG_IDX_W + 2;
    localparam int PDATA_W       = 32;

    localparam logic [REG_IDX_W-1:0] REG_DLEN0 = 3'd4;

endpackage

/* src/fdn_reverb_householder.sv */
// top level: four-line feedback delay network reverb, Householder mix
//
// Input channel: in_valid/in_stall with in_sample (signed Q1.23) and in_last.
// Output channel: out_valid/out_stall with out_sample and out_last; one
// result per item, in order. Gains and delay lengths sit on an APB-style
// port (pready always high). The user must write them only while the
// block is idle; the block itself does not enforce this.
// A new item is accepted only once the one before has been through the
// feedback loop: delay read, damping add with the gain multiply, the
// mix reciprocal multiply and the write-back of all lines must close
// before the next item reads a line set to a delay of one sample.
// Each line has its own bank, read once and written once per item; a
// delay of one sample is forwarded from the write-back register.
// Reset clears the damping state, the write position and the gains and
// sets the delay lengths to one; a fill count makes never-written taps
// read as zero, so no clearing pass over the delay memory is needed.
// Results wait in a three-entry queue; when the receiver stalls, input
// is stalled once three items are accepted and not yet delivered.
module fdn_reverb_householder
    import fdnrh_pkg::*;
#(
    parameter int LINES       = LINES_DEF,
    parameter int MAX_DELAY   = MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic                          out_last
);

    localparam int SW     = SAMPLE_BITS;
    localparam int AW     = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int FW     = $clog2(MAX_DELAY + 1);
    localparam int SUM_W  = SW + 2;
    localparam int MIX_W  = SW + 3;
    localparam int Y_W    = SW + 4;
    localparam int II     = 3;
    localparam int GAP_W  = 2;
    localparam int QD     = 3;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 2;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    // ---------------------------------------------------------------
    // register file
    // ---------------------------------------------------------------
    logic [GAIN_W-1:0]    gain_reg [NUM_LINE_REGS];
    logic [LEN_W-1:0]     dlen_reg [NUM_LINE_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic [LINE_IDX_W-1:0] reg_line;
    logic                 cfg_wr;

    assign pready   = 1'b1;
    assign reg_idx  = paddr[PADDR_W-1:2];
    assign reg_line = reg_idx[LINE_IDX_W-1:0];
    assign cfg_wr   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINE_REGS; i++)
            begin
                gain_reg[i] <= '0;
                dlen_reg[i] <= LEN_W'(1);
            end
        end
        else if (cfg_wr)
        begin
            if (reg_idx < REG_DLEN0)
            begin
                gain_reg[reg_line] <= pwdata[GAIN_W-1:0];
            end
            else
            begin
                dlen_reg[reg_line] <= pwdata[LEN_W-1:0];
            end
        end
    end

    // register read-back
    always_comb
    begin
        if (reg_idx < REG_DLEN0)
        begin
            prdata = PDATA_W'(gain_reg[reg_line]);
        end
        else
        begin
            prdata = PDATA_W'(dlen_reg[reg_line]);
        end
    end

    // ---------------------------------------------------------------
    // input handshake, issue spacing and outstanding item count
    // ---------------------------------------------------------------
    logic              run_reg;
    logic [GAP_W-1:0]  gap_reg;
    logic [QCNT_W-1:0] credit_reg;
    logic [QCNT_W-1:0] credit_next;
    logic              in_acc;
    logic              out_acc;

    assign in_stall = !run_reg || (gap_reg != '0) || (credit_reg == QCNT_W'(QD));
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    always_comb
    begin
        credit_next = credit_reg;
        if (in_acc && !out_acc)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (!in_acc && out_acc)
        begin
            credit_next = credit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            gap_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            run_reg    <= 1'b1;
            credit_reg <= credit_next;
            if (in_acc)
            begin
                gap_reg <= GAP_W'(II - 1);
            end
            else if (gap_reg != '0)
            begin
                gap_reg <= gap_reg - 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // write position, fill count and stage valids
    // ---------------------------------------------------------------
    logic [AW-1:0] acc_wp_reg;
    logic [AW-1:0] pipe_wp_reg;
    logic [FW-1:0] fill_reg;
    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_wp_reg <= '0;
            fill_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            if (in_acc)
            begin
                if (acc_wp_reg == AW'(MAX_DELAY - 1))
                begin
                    acc_wp_reg <= '0;
                end
                else
                begin
                    acc_wp_reg <= acc_wp_reg + 1'b1;
                end
                if (fill_reg != FW'(MAX_DELAY))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
        end
    end

    // item payload captured at accept
    logic signed [SW-1:0] x_reg;
    logic                 last_reg;
    logic                 last3_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg       <= in_sample;
            last_reg    <= in_last;
            pipe_wp_reg <= acc_wp_reg;
        end
        if (s3_vld_reg)
        begin
            last3_reg <= last_reg;
        end
    end

    // ---------------------------------------------------------------
    // per-line lanes: tap read, damping, gain, write-back
    // ---------------------------------------------------------------
    logic signed [SW-1:0] damp_reg [LINES];
    logic signed [SW-1:0] d_reg    [LINES];
    logic signed [SW-1:0] y_reg    [LINES];
    logic signed [SW-1:0] y_next   [LINES];
    logic [SW-1:0]        rd_q     [LINES];
    logic [LINES-1:0]     rd_ok_reg;
    logic [LINES-1:0]     fwd_reg;
    logic signed [MIX_W-1:0] mix;

    for (genvar g = 0; g < LINES; g++)
    begin : g_line
        logic [FW-1:0]           len_eff;
        logic [31:0]             len32;
        logic [FW:0]             tap;
        logic [AW-1:0]           rd_addr;
        logic signed [SW-1:0]    raw;
        logic signed [SW:0]      damp_sum;
        logic signed [SW-1:0]    filt;
        logic signed [SW+GAIN_W:0] prod;
        logic signed [Y_W-1:0]   y_wide;

        // effective delay: zero acts as one, clipped to the line length
        always_comb
        begin
            len32 = 32'(dlen_reg[g]);
            if (len32 == 32'd0)
            begin
                len_eff = FW'(1);
            end
            else if (len32 > 32'(MAX_DELAY))
            begin
                len_eff = FW'(MAX_DELAY);
            end
            else
            begin
                len_eff = FW'(len32);
            end
        end

        // tap address, modulo the line length
        always_comb
        begin
            tap = (FW+1)'(acc_wp_reg) + (FW+1)'(MAX_DELAY) - (FW+1)'(len_eff);
            if (tap >= (FW+1)'(MAX_DELAY))
            begin
                tap = tap - (FW+1)'(MAX_DELAY);
            end
            rd_addr = tap[AW-1:0];
        end

        // tap status: never written reads zero, one-sample delay forwards
        always_ff @(posedge clk)
        begin
            if (in_acc)
            begin
                rd_ok_reg[g] <= (len_eff <= fill_reg);
                fwd_reg[g]   <= (len_eff == FW'(1));
            end
        end

        fdnrh_delay_ram #(
            .DEPTH (MAX_DELAY),
            .DW    (SW)
        ) u_ram (
            .clk     (clk),
            .wr_en   (s3_vld_reg),
            .wr_addr (pipe_wp_reg),
            .wr_data (y_next[g]),
            .rd_en   (in_acc),
            .rd_addr (rd_addr),
            .rd_data (rd_q[g])
        );

        // damping lowpass and feedback gain
        always_comb
        begin
            if (!rd_ok_reg[g])
            begin
                raw = '0;
            end
            else if (fwd_reg[g])
            begin
                raw = y_reg[g];
            end
            else
            begin
                raw = $signed(rd_q[g]);
            end
            damp_sum = {raw[SW-1], raw} + {damp_reg[g][SW-1], damp_reg[g]};
            filt     = damp_sum[SW:1];
            prod     = filt * $signed({1'b0, gain_reg[g]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                damp_reg[g] <= '0;
            end
            else if (s1_vld_reg)
            begin
                damp_reg[g] <= filt;
            end
        end

        always_ff @(posedge clk)
        begin
            if (s1_vld_reg)
            begin
                d_reg[g] <= prod[SW+15:16];
            end
            if (s3_vld_reg)
            begin
                y_reg[g] <= y_next[g];
            end
        end

        // householder mix and saturation
        always_comb
        begin
            y_wide = {{(Y_W-SW){d_reg[g][SW-1]}}, d_reg[g]}
                   - {mix[MIX_W-1], mix}
                   + {{(Y_W-SW){x_reg[SW-1]}}, x_reg};
            if ((y_wide[Y_W-1:SW-1] == '0) || (y_wide[Y_W-1:SW-1] == '1))
            begin
                y_next[g] = y_wide[SW-1:0];
            end
            else if (y_wide[Y_W-1])
            begin
                y_next[g] = S_MIN;
            end
            else
            begin
                y_next[g] = S_MAX;
            end
        end
    end

    // ---------------------------------------------------------------
    // mix term: floor(2 * sum(d) / LINES)
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_d;
    logic signed [MIX_W-1:0] mix_num;

    always_comb
    begin
        sum_d = '0;
        for (int i = 0; i < LINES; i++)
        begin
            sum_d = sum_d + {{(SUM_W-SW){d_reg[i][SW-1]}}, d_reg[i]};
        end
        mix_num = {sum_d, 1'b0};
    end

    fdnrh_floor_div #(
        .W   (MIX_W),
        .DIV (LINES)
    ) u_mix_div (
        .clk (clk),
        .num (mix_num),
        .quo (mix)
    );

    // ---------------------------------------------------------------
    // output: floor(sum(Y) / LINES), saturated
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] avg;
    logic signed [SW-1:0]    res;

    always_comb
    begin
        sum_y = '0;
        for (int i = 0; i < LINES; i++)
        begin
            sum_y = sum_y + {{(SUM_W-SW){y_reg[i][SW-1]}}, y_reg[i]};
        end
    end

    fdnrh_floor_div #(
        .W   (SUM_W),
        .DIV (LINES)
    ) u_out_div (
        .clk (clk),
        .num (sum_y),
        .quo (avg)
    );

    always_comb
    begin
        if ((avg[SUM_W-1:SW-1] == '0) || (avg[SUM_W-1:SW-1] == '1))
        begin
            res = avg[SW-1:0];
        end
        else if (avg[SUM_W-1])
        begin
            res = S_MIN;
        end
        else
        begin
            res = S_MAX;
        end
    end

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    logic signed [SW-1:0] q_sample [QD];
    logic                 q_last   [QD];
    logic [QPTR_W-1:0]    q_head_reg;
    logic [QPTR_W-1:0]    q_tail_reg;
    logic [QCNT_W-1:0]    q_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (s5_vld_reg)
        begin
            q_sample[q_tail_reg] <= res;
            q_last[q_tail_reg]   <= last3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (s5_vld_reg)
            begin
                q_tail_reg <= (q_tail_reg == QPTR_W'(QD - 1)) ? '0 : q_tail_reg + 1'b1;
            end
            if (out_acc)
            begin
                q_head_reg <= (q_head_reg == QPTR_W'(QD - 1)) ? '0 : q_head_reg + 1'b1;
            end
            if (s5_vld_reg && !out_acc)
            begin
                q_cnt_reg <= q_cnt_reg + 1'b1;
            end
            else if (!s5_vld_reg && out_acc)
            begin
                q_cnt_reg <= q_cnt_reg - 1'b1;
            end
        end
    end

    assign out_valid  = (q_cnt_reg != '0);
    assign out_sample = q_sample[q_head_reg];
    assign out_last   = q_last[q_head_reg];

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // items enter no closer than the loop interval
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_acc ##1 !in_acc)
        else $error("items accepted closer than the loop interval");

    // each accepted item is written back exactly at the end of its loop
    a_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> ##3 s3_vld_reg)
        else $error("write-back missing for an accepted item");

    // the queue is never pushed while full unless it also pops
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> (q_cnt_reg != QCNT_W'(QD)) || out_acc)
        else $error("result queue overflow");

    // a result is shown only while an item is outstanding
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (credit_reg != '0) && (q_cnt_reg <= credit_reg))
        else $error("result queue out of step with outstanding items");

endmodule

/* src/fdnrh_delay_ram.sv */
// one delay line bank: simple dual-port memory, registered read
module fdnrh_delay_ram
    import fdnrh_pkg::*;
#(
    parameter int DEPTH = MAX_DELAY_DEF,
    parameter int DW    = SAMPLE_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem_array [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/fdnrh_floor_div.sv */
// signed floor division by a small constant via exact reciprocal multiply
module fdnrh_floor_div
    import fdnrh_pkg::*;
#(
    parameter int W   = SAMPLE_BITS_DEF + 3,
    parameter int DIV = LINES_DEF
)(
    input  logic                clk,
    input  logic signed [W-1:0] num,
    output logic signed [W-1:0] quo
);

    // biased operand is non-negative and below 2^N
    localparam int N  = W + 2;
    localparam int L2 = $clog2(DIV);
    localparam longint unsigned MUL_FULL =
        ((64'd1 << (N + L2)) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [N:0]   MUL    = MUL_FULL[N:0];
    localparam logic [N-1:0] OFFSET = N'(DIV) << (W - 1);
    localparam logic [W-1:0] BIAS   = {1'b1, {(W-1){1'b0}}};

    logic [N-1:0] ubias;
    logic [2*N:0] prod_reg;

    // shift the operand into the non-negative range
    assign ubias = {{2{num[W-1]}}, num} + OFFSET;

    // reciprocal multiply, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= ubias * MUL;
    end

    // take the quotient and remove the bias
    assign quo = $signed(prod_reg[N+L2 +: W] - BIAS);

endmodule

/* sim/fdn_reverb_householder_tb.sv */
// testbench for the four-line feedback delay network reverb
`timescale 1ns / 100ps

module fdn_reverb_householder_tb
    import fdnrh_pkg::*;
();

    localparam int NL          = LINES_DEF;
    localparam int MAXD        = MAX_DELAY_DEF;
    localparam int SB          = SAMPLE_BITS_DEF;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_ROWS      = 21;
    localparam int MAX_REPORTS = 10;

    // register indexes beside the one the package names
    localparam logic [REG_IDX_W-1:0] REG_GAIN0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DLEN1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DLEN2 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DLEN3 = 3'd7;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 last;
    } wet_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [REG_IDX_W-1:0]  idx;
        logic [PDATA_W-1:0]    word;
        logic                  last;
        logic                  has_wet;
        logic [SB-1:0]         wet;
    } stim_row_t;

    // directed part: extremes right after reset (dry passes straight
    // through with zero gain), then full gain with zero, one, max and
    // oversized delays, driving the mix into saturation
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{ROW_ITEM, REG_GAIN0, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF},
        '{ROW_ITEM, REG_GAIN0, 32'h0080_0000, 1'b1, 1'b1, 24'h80_0000},
        '{ROW_ITEM, REG_GAIN0, 32'h0000_0000, 1'b0, 1'b1, 24'h00_0000},
        '{ROW_ITEM, REG_GAIN0, 32'h00FF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF},
        '{ROW_ITEM, REG_GAIN0, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0001},
        '{ROW_REG,  REG_GAIN0, 32'hFFFF_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_GAIN1, 32'h0000_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_GAIN2, 32'hFFFF_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_GAIN3, 32'h0000_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_DLEN0, 32'h0000_0000, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_DLEN1, 32'h0000_0001, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_DLEN2, 32'h0000_2000, 1'b0, 1'b0, 24'h0},
        '{ROW_REG,  REG_DLEN3, 32'h0000_3FFF, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h007F_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h007F_FFFF, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h0080_0000, 1'b1, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h0080_0000, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h007F_FFFF, 1'b1, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h0000_0001, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h0080_0000, 1'b0, 1'b0, 24'h0},
        '{ROW_ITEM, REG_GAIN0, 32'h002A_AAAA, 1'b1, 1'b0, 24'h0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [SB-1:0] in_sample;
    logic                 in_last;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [SB-1:0] out_sample;
    logic                 out_last;

    // reverb state as the block should hold it
    logic signed [SB-1:0] line_mem [NL][MAXD];
    int unsigned          wr_pos [NL];
    longint               damp_mem [NL];
    logic [GAIN_W-1:0]    gain_reg [NL];
    logic [LEN_W-1:0]     dly_reg [NL];

    wet_t        wet_due_q [$];
    int          miss_cnt;
    int unsigned cycle_cnt = 0;
    bit          idle_on;

    fdn_reverb_householder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_sample  (in_sample),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .out_last   (out_last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL fdn_reverb_householder");
            $finish;
        end
    end

    function automatic longint sat_sample(input longint v);
        longint hi;
        hi = (longint'(1) <<< (SB - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // one sample through the four lines; shifts are floor divisions
    // (by two for the damping, by the four lines for mix and output)
    function automatic wet_t reverb_predict(input logic signed [SB-1:0] x, input logic l);
        longint      d [NL];
        longint      y [NL];
        longint      sum_d;
        longint      sum_y;
        longint      mix;
        longint      raw;
        longint      filt;
        int unsigned len;
        int unsigned rp;
        wet_t        w;
        sum_d = 0;
        sum_y = 0;
        for (int i = 0; i < NL; i++)
        begin
            len = 32'(dly_reg[i]);
            if (len == 0)
                len = 1;
            if (len > MAXD)
                len = MAXD;
            rp = (wr_pos[i] + MAXD - len) % MAXD;
            raw = longint'(line_mem[i][rp]);
            filt = (raw + damp_mem[i]) >>> 1;
            damp_mem[i] = filt;
            d[i] = (filt * longint'(gain_reg[i])) >>> 16;
            sum_d += d[i];
        end
        mix = (2 * sum_d) >>> 2;
        for (int i = 0; i < NL; i++)
        begin
            y[i] = sat_sample(d[i] - mix + longint'(x));
            sum_y += y[i];
        end
        // write-back into each line
        for (int i = 0; i < NL; i++)
        begin
            line_mem[i][wr_pos[i]] = y[i][SB-1:0];
            wr_pos[i] = (wr_pos[i] + 1) % MAXD;
        end
        w.sample = SB'(sat_sample(sum_y >>> 2));
        w.last = l;
        return w;
    endfunction

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 7) : 0;
    endfunction

    // one item on the input channel, predicted at the accepting edge
    task automatic send_item(input logic signed [SB-1:0] s, input logic l,
                             input logic has_wet, input logic signed [SB-1:0] wet);
        int   gap;
        wet_t w;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        in_sample <= s;
        in_last   <= l;
        do @(posedge clk); while (in_stall);
        w = reverb_predict(s, l);
        if (has_wet)
            w.sample = wet;
        wet_due_q.push_back(w);
    endtask

    // let every outstanding result come back, then settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (wet_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // setup and access cycle on the register port
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] word);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx < REG_DLEN0)
            gain_reg[idx[LINE_IDX_W-1:0]] = word[GAIN_W-1:0];
        else
            dly_reg[idx[LINE_IDX_W-1:0]] = word[LEN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // output side: random stall, then compare with the oldest expectation
    initial
    begin
        int   n;
        wet_t w;
        out_stall = 1'b0;
        miss_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            n = draw_wait();
            repeat (n)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (wet_due_q.size() == 0)
            begin
                if (miss_cnt < MAX_REPORTS)
                    $display("unexpected item: sample %0d last %0b", out_sample, out_last);
                miss_cnt++;
            end
            else
            begin
                w = wet_due_q.pop_front();
                if (out_sample !== w.sample || out_last !== w.last)
                begin
                    if (miss_cnt < MAX_REPORTS)
                        $display("mismatch: sample exp %0d got %0d, last exp %0b got %0b",
                                 w.sample, out_sample, w.last, out_last);
                    miss_cnt++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic signed [SB-1:0] s;
        logic [PDATA_W-1:0]   word;
        logic [LEN_W-1:0]     len;
        logic [GAIN_W-1:0]    g;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        in_sample = '0;
        in_last   = 1'b0;
        idle_on   = 1'b1;
        for (int i = 0; i < NL; i++)
        begin
            wr_pos[i]   = 0;
            damp_mem[i] = 0;
            gain_reg[i] = '0;
            dly_reg[i]  = LEN_W'(1);
            for (int k = 0; k < MAXD; k++)
                line_mem[i][k] = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_REG)
            begin
                drain();
                reg_write(DIR_ROWS[r].idx, DIR_ROWS[r].word);
            end
            else
                send_item(DIR_ROWS[r].word[SB-1:0], DIR_ROWS[r].last,
                          DIR_ROWS[r].has_wet, DIR_ROWS[r].wet);
        end

        // random phases, each with fresh gains and delays; lines keep
        // their contents across the change
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            idle_on = (p % 3 != 1);
            for (int i = 0; i < NL; i++)
            begin
                case ($urandom_range(0, 3))
                    0:       g = '0;
                    1:       g = '1;
                    default: g = GAIN_W'($urandom_range(16384, 65535));
                endcase
                word = $urandom;
                word[GAIN_W-1:0] = g;
                reg_write(REG_GAIN0 + REG_IDX_W'(i), word);
            end
            for (int i = 0; i < NL; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       len = '0;
                    1:       len = LEN_W'(MAXD);
                    2:       len = LEN_W'($urandom_range(MAXD + 1, 16383));
                    3:       len = LEN_W'($urandom_range(1, MAXD));
                    default: len = LEN_W'($urandom_range(1, 40));
                endcase
                word = $urandom;
                word[LEN_W-1:0] = len;
                reg_write(REG_DLEN0 + REG_IDX_W'(i), word);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       s = {1'b0, {(SB-1){1'b1}}};
                    1:       s = {1'b1, {(SB-1){1'b0}}};
                    2:       s = SB'($signed($urandom_range(0, 511)) - 256);
                    default: s = SB'($urandom);
                endcase
                send_item(s, 1'($urandom), 1'b0, '0);
            end
        end

        drain();
        if (miss_cnt == 0)
            $display("PASS fdn_reverb_householder");
        else
            $display("FAIL fdn_reverb_householder");
        $finish;
    end

endmodule
